[hdl/cscs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscs_pkg
// Shared constants of the cumulative share channel selector.
// ----------------------------------------------------------------------------
package cscs_pkg;
    localparam int SLOT_BITS  = 6;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int ACC_BITS   = 7;
    localparam int RATE_PORT_BITS = 32;
    localparam logic [ACC_BITS-1:0] PCT_FULL  = 7'd100;
    localparam logic [ACC_BITS-1:0] ACC_RESET = 7'd10;
endpackage

[hdl/cumulative_share_channel_selector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cumulative_share_channel_selector
// Keeps, per bin, the channels that carry the top share of the total rate.
// ----------------------------------------------------------------------------
// A bin end with a nonzero total rate holds busy while the entry memory is
// scanned pairwise through its single read port (one entry per cycle).
// A group end then emits one verdict per cycle, group_channels verdicts.
// Reset (synchronous, active low) clears fill count, sum and flags, and sets the share register to ACC_RESET.
// Results are strobed for one cycle and cannot be stalled.
module cumulative_share_channel_selector #(
    parameter int MAX_CHANNELS = 64,
    parameter int RATE_BITS    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cscs_pkg::ACC_BITS-1:0]     i_cfg_wdata,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [cscs_pkg::RATE_PORT_BITS-1:0] i_rate_value,
    input  logic [cscs_pkg::SLOT_BITS-1:0]    i_channel_slot,
    input  logic                              i_bin_end,
    input  logic                              i_group_end,
    output logic                              o_valid,
    output logic [cscs_pkg::SLOT_BITS-1:0]    o_out_slot,
    output logic                              o_important,
    output logic                              o_last
);
    localparam int SB = cscs_pkg::SLOT_BITS;
    localparam int AB = cscs_pkg::ACC_BITS;
    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int SW = RATE_BITS + CW;
    localparam int PW = SW + AB;
    localparam int EW = RATE_BITS + SB;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_LOAD_I, ST_HOLD_I, ST_SCAN, ST_PROD, ST_CMP, ST_OUT
    } t_state;

    t_state r_state;
    logic [AB-1:0] r_acc;
    logic [CW-1:0] r_fill, r_n, r_i, r_j;
    logic [SW-1:0] r_sum, r_cum;
    logic [PW-1:0] r_tsum, r_prod;
    logic [RATE_BITS-1:0] r_ri;
    logic [SB-1:0] r_si;
    logic r_pv, r_ge;
    logic [SB:0] r_gch;
    logic [SB:0] r_k;
    logic [cscs_pkg::SLOT_COUNT-1:0] r_flags, r_clr, r_set;
    logic [EW-1:0] r_mem [MAX_CHANNELS];
    logic [EW-1:0] r_rd;

    logic [RATE_BITS-1:0] w_rate;
    logic                 w_store;
    logic [SW-1:0]        n_sum;
    logic [CW-1:0]        n_fill;
    logic [AW-1:0]        w_rd_addr;
    logic [AB-1:0]        w_thr;
    logic [RATE_BITS-1:0] w_rj;
    logic [SB-1:0]        w_sj;

    assign w_rate  = RATE_BITS'(i_rate_value);
    assign w_store = r_fill < CW'(MAX_CHANNELS);
    assign n_sum   = r_sum + (w_store ? SW'(w_rate) : SW'(0));
    assign n_fill  = w_store ? r_fill + CW'(1) : r_fill;
    assign w_thr   = (r_acc >= cscs_pkg::PCT_FULL) ? AB'(0) : cscs_pkg::PCT_FULL - r_acc;
    assign w_rj    = r_rd[EW-1:SB];
    assign w_sj    = r_rd[SB-1:0];
    assign o_busy  = r_state != ST_IDLE;

    always_comb begin
        if (r_state == ST_SCAN) begin
            w_rd_addr = r_j[AW-1:0];
        end else begin
            w_rd_addr = r_i[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start && w_store) begin
            r_mem[r_fill[AW-1:0]] <= {w_rate, i_channel_slot};
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= cscs_pkg::ACC_RESET;
            r_fill      <= '0;
            r_sum       <= '0;
            r_gch       <= '0;
            r_flags     <= '0;
            r_clr       <= '0;
            r_set       <= '0;
            r_pv        <= 1'b0;
            r_ge        <= 1'b0;
            o_valid     <= 1'b0;
            o_out_slot  <= '0;
            o_important <= 1'b0;
            o_last      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_acc <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_ge <= i_group_end;
                        if ((SB + 1)'(i_channel_slot) + 1'b1 > r_gch) begin
                            r_gch <= (SB + 1)'(i_channel_slot) + 1'b1;
                        end
                        if (i_bin_end || i_group_end) begin
                            r_n    <= n_fill;
                            r_sum  <= n_sum;
                            r_fill <= '0;
                            if (n_sum != '0) begin
                                r_state <= ST_SETUP;
                            end else if (i_group_end) begin
                                r_k     <= '0;
                                r_state <= ST_OUT;
                            end
                        end else begin
                            r_fill <= n_fill;
                            r_sum  <= n_sum;
                        end
                    end
                end
                ST_SETUP: begin
                    r_tsum  <= PW'(r_sum) * PW'(w_thr);
                    r_i     <= '0;
                    r_state <= ST_LOAD_I;
                end
                ST_LOAD_I: begin
                    r_state <= ST_HOLD_I;
                end
                ST_HOLD_I: begin
                    r_ri <= w_rj;
                    r_si <= w_sj;
                    if (w_rj == '0) begin
                        // Zero entries sort first, so clears precede every set.
                        r_clr[w_sj] <= 1'b1;
                        r_i <= r_i + CW'(1);
                        r_state <= (r_i + CW'(1) == r_n) ? ST_CMP : ST_LOAD_I;
                    end else begin
                        r_j     <= '0;
                        r_pv    <= 1'b0;
                        r_cum   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_pv <= r_j < r_n;
                    if (r_j < r_n) begin
                        r_j <= r_j + CW'(1);
                    end
                    // Equal rates are ordered by slot: an equal entry counts only if its slot is not higher.
                    if (r_pv && ((w_rj < r_ri) || (w_rj == r_ri && w_sj <= r_si))) begin
                        r_cum <= r_cum + SW'(w_rj);
                    end
                    if (!(r_j < r_n) && !r_pv) begin
                        r_state <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    r_prod <= (PW'(r_cum) << 6) + (PW'(r_cum) << 5) + (PW'(r_cum) << 2);
                    r_i    <= r_i + CW'(1);
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (r_ri != '0 && r_prod > r_tsum) begin
                        r_set[r_si] <= 1'b1;
                    end
                    r_ri <= '0;
                    if (r_i == r_n) begin
                        r_flags <= (r_flags & ~r_clr) | r_set
                                   | (r_ri != '0 && r_prod > r_tsum ?
                                      (cscs_pkg::SLOT_COUNT)'(1) << r_si : '0);
                        r_clr <= '0;
                        r_set <= '0;
                        r_sum <= '0;
                        r_k   <= '0;
                        r_state <= r_ge ? ST_OUT : ST_IDLE;
                    end else begin
                        r_state <= ST_LOAD_I;
                    end
                end
                ST_OUT: begin
                    o_valid     <= 1'b1;
                    o_out_slot  <= r_k[SB-1:0];
                    o_important <= r_flags[r_k[SB-1:0]];
                    o_last      <= r_k + 1'b1 == r_gch;
                    r_k         <= r_k + 1'b1;
                    if (r_k + 1'b1 == r_gch) begin
                        r_flags <= '0;
                        r_gch   <= '0;
                        r_fill  <= '0;
                        r_sum   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

[hdl/cscs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscs_checker
// Port-level checks of the verdict stream of the channel selector.
// ----------------------------------------------------------------------------
module cscs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_busy,
    input logic                           o_valid,
    input logic [cscs_pkg::SLOT_BITS-1:0] o_out_slot,
    input logic                           o_last
);
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_busy)
        else $error("outputs active after reset");
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("verdict burst broken");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_out_slot == $past(o_out_slot) + 1'b1)
        else $error("verdict slots out of order");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(o_valid) |-> o_out_slot == '0)
        else $error("verdict burst does not start at slot zero");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("verdict after the last of a group");
endmodule

bind cumulative_share_channel_selector cscs_checker u_cscs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_busy     (o_busy),
    .o_valid    (o_valid),
    .o_out_slot (o_out_slot),
    .o_last     (o_last)
);
